/* rtl/rfp_pkg.sv */
package rfp_pkg;

  // Request table size (1 to 16 entries).
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [7:0]  HEADER_BYTE_RST     = 8'd0;
  localparam logic [15:0] HEADER_TIMEOUT_RST  = 16'd5000;
  localparam logic [15:0] BODY_TIMEOUT_RST    = 16'd10000;
  localparam logic [31:0] ENTRY_AGE_LIMIT_RST = 32'd3600000;

  typedef enum logic [1:0] {
    CFG_HEADER_BYTE     = 2'd0,
    CFG_HEADER_TIMEOUT  = 2'd1,
    CFG_BODY_TIMEOUT    = 2'd2,
    CFG_ENTRY_AGE_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_RECORD = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FRAME_OK  = 3'd0,
    KIND_BAD_CHECK = 3'd1,
    KIND_HDR_TO    = 3'd2,
    KIND_BODY_TO   = 3'd3,
    KIND_RECORDED  = 3'd4,
    KIND_FULL      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SCAN = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic res_valid;
    logic out_free;
  } sts_t;

endpackage

/* rtl/rfp_ctrl.sv */
module rfp_ctrl import rfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts.need_scan ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.res_valid || sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // input held off while reset is asserted and outside idle; command strobes decoded from the state
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !rst_n;
        cmd.load = in_valid && rst_n;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_SCAN: cmd.scan = 1'b1;
      ST_EMIT: cmd.emit = sts.res_valid && sts.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

/* rtl/rfp_dp.sv */
module rfp_dp import rfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_request_seq,
  input  logic [6:0]  in_request_ctrl,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_frame_seq,
  output logic [7:0]  out_frame_ctrl,
  output logic [15:0] out_payload_length,
  output logic        out_matched,
  output logic [3:0]  out_entry_index,
  input  cmd_t        cmd,
  output sts_t        sts
);

  // configuration
  logic [7:0]  hdr_byte_r;
  logic [15:0] hdr_to_r;
  logic [15:0] body_to_r;
  logic [31:0] age_lim_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  hseq_r, hseq_nxt;
  logic [7:0]  hctrl_r, hctrl_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [31:0] start_m1_r, start_m1_nxt;  // phase start time minus one
  logic [31:0] time_r, time_nxt;

  // latched item
  op_t         op_r;
  logic [7:0]  byte_r;
  logic [7:0]  rseq_r;
  logic [6:0]  rctrl_r;

  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;

  // pending result
  logic        res_valid_r, res_valid_nxt;
  kind_t       res_kind_r, res_kind_nxt;
  logic [7:0]  res_seq_r, res_seq_nxt;
  logic [7:0]  res_ctrl_r, res_ctrl_nxt;
  logic [15:0] res_len_r, res_len_nxt;
  logic        res_hit_r, res_hit_nxt;
  logic [3:0]  res_idx_r, res_idx_nxt;

  // output word
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r;
  logic [7:0]  out_seq_r;
  logic [7:0]  out_ctrl_r;
  logic [15:0] out_len_r;
  logic        out_hit_r;
  logic [3:0]  out_idx_r;

  // request table
  logic [7:0]  ent_seq_r  [TABLE_ENTRIES];
  logic [6:0]  ent_ctrl_r [TABLE_ENTRIES];
  logic [31:0] ent_time_r [TABLE_ENTRIES];
  logic [7:0]  ent_seq_nxt  [TABLE_ENTRIES];
  logic [6:0]  ent_ctrl_nxt [TABLE_ENTRIES];
  logic [31:0] ent_time_nxt [TABLE_ENTRIES];

  logic need_scan;
  logic scan_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_byte_r  <= HEADER_BYTE_RST;
      hdr_to_r    <= HEADER_TIMEOUT_RST;
      body_to_r   <= BODY_TIMEOUT_RST;
      age_lim_r   <= ENTRY_AGE_LIMIT_RST;
      phase_r     <= PH_HUNT;
      pos_r       <= '0;
      time_r      <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent_ctrl_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_HEADER_BYTE:     hdr_byte_r <= cfg_data[7:0];
          CFG_HEADER_TIMEOUT:  hdr_to_r   <= cfg_data[15:0];
          CFG_BODY_TIMEOUT:    body_to_r  <= cfg_data[15:0];
          CFG_ENTRY_AGE_LIMIT: age_lim_r  <= cfg_data;
          default:             hdr_byte_r <= hdr_byte_r;
        endcase
      end
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      time_r      <= time_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ent_ctrl_r  <= ent_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_opcode);
      byte_r  <= in_rx_byte;
      rseq_r  <= in_request_seq;
      rctrl_r <= in_request_ctrl;
    end
    if (cmd.emit) begin
      out_kind_r <= res_kind_r;
      out_seq_r  <= res_seq_r;
      out_ctrl_r <= res_ctrl_r;
      out_len_r  <= res_len_r;
      out_hit_r  <= res_hit_r;
      out_idx_r  <= res_idx_r;
    end
    hseq_r     <= hseq_nxt;
    hctrl_r    <= hctrl_nxt;
    hlen_r     <= hlen_nxt;
    xor_r      <= xor_nxt;
    start_m1_r <= start_m1_nxt;
    scan_idx_r <= scan_idx_nxt;
    res_kind_r <= res_kind_nxt;
    res_seq_r  <= res_seq_nxt;
    res_ctrl_r <= res_ctrl_nxt;
    res_len_r  <= res_len_nxt;
    res_hit_r  <= res_hit_nxt;
    res_idx_r  <= res_idx_nxt;
    ent_seq_r  <= ent_seq_nxt;
    ent_time_r <= ent_time_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    hseq_nxt      = hseq_r;
    hctrl_nxt     = hctrl_r;
    hlen_nxt      = hlen_r;
    xor_nxt       = xor_r;
    start_m1_nxt  = start_m1_r;
    time_nxt      = time_r;
    scan_idx_nxt  = scan_idx_r;
    res_valid_nxt = res_valid_r;
    res_kind_nxt  = res_kind_r;
    res_seq_nxt   = res_seq_r;
    res_ctrl_nxt  = res_ctrl_r;
    res_len_nxt   = res_len_r;
    res_hit_nxt   = res_hit_r;
    res_idx_nxt   = res_idx_r;
    ent_seq_nxt   = ent_seq_r;
    ent_ctrl_nxt  = ent_ctrl_r;
    ent_time_nxt  = ent_time_r;
    need_scan     = 1'b0;
    scan_hit      = 1'b0;

    if (cmd.exec) begin
      scan_idx_nxt  = '0;
      res_valid_nxt = 1'b0;
      res_kind_nxt  = KIND_FRAME_OK;
      res_seq_nxt   = '0;
      res_ctrl_nxt  = '0;
      res_len_nxt   = '0;
      res_hit_nxt   = 1'b0;
      res_idx_nxt   = '0;
      unique case (op_r)
        OP_BYTE: begin
          unique case (phase_r)
            PH_HEAD: begin
              xor_nxt = xor_r ^ byte_r;
              pos_nxt = pos_r + 16'd1;
              priority if (pos_r == 16'd1) begin
                hseq_nxt = byte_r;
              end else if (pos_r == 16'd2) begin
                hctrl_nxt = byte_r;
              end else if (pos_r == 16'd3) begin
                hlen_nxt = {byte_r, 8'h00};
              end else begin
                hlen_nxt     = {hlen_r[15:8], byte_r};
                phase_nxt    = PH_BODY;
                pos_nxt      = '0;
                start_m1_nxt = time_r - 32'd1;
              end
            end
            PH_BODY: begin
              if (pos_r < hlen_r) begin
                xor_nxt = xor_r ^ byte_r;
                pos_nxt = pos_r + 16'd1;
              end else begin
                phase_nxt     = PH_HUNT;
                pos_nxt       = '0;
                res_valid_nxt = 1'b1;
                res_seq_nxt   = hseq_r;
                res_ctrl_nxt  = hctrl_r;
                res_len_nxt   = hlen_r;
                if (byte_r != xor_r) begin
                  res_kind_nxt = KIND_BAD_CHECK;
                end else begin
                  res_kind_nxt = KIND_FRAME_OK;
                  need_scan    = 1'b1;
                end
              end
            end
            default: begin
              phase_nxt = PH_HUNT;
              if (byte_r == hdr_byte_r) begin
                phase_nxt    = PH_HEAD;
                pos_nxt      = 16'd1;
                xor_nxt      = byte_r;
                hseq_nxt     = '0;
                hctrl_nxt    = '0;
                hlen_nxt     = '0;
                start_m1_nxt = time_r - 32'd1;
              end
            end
          endcase
        end
        OP_RECORD: begin
          need_scan     = 1'b1;
          res_valid_nxt = 1'b1;
          res_kind_nxt  = KIND_FULL;
        end
        OP_TICK: begin
          time_nxt  = time_r + 32'd1;
          need_scan = 1'b1;
          // new time minus start equals old time minus (start - 1)
          if (phase_r == PH_HEAD && (time_r - start_m1_r) > {16'd0, hdr_to_r}) begin
            phase_nxt     = PH_HUNT;
            pos_nxt       = '0;
            res_valid_nxt = 1'b1;
            res_kind_nxt  = KIND_HDR_TO;
          end else if (phase_r == PH_BODY &&
                       (time_r - start_m1_r) > {16'd0, body_to_r}) begin
            phase_nxt     = PH_HUNT;
            pos_nxt       = '0;
            res_valid_nxt = 1'b1;
            res_kind_nxt  = KIND_BODY_TO;
            res_seq_nxt   = hseq_r;
            res_ctrl_nxt  = hctrl_r;
            res_len_nxt   = hlen_r;
          end
        end
        default: need_scan = 1'b0;
      endcase
    end

    if (cmd.scan) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
      unique case (op_r)
        OP_BYTE: begin
          if (ent_ctrl_r[scan_idx_r] != 7'd0 && ent_seq_r[scan_idx_r] == hseq_r &&
              {1'b1, ent_ctrl_r[scan_idx_r]} == hctrl_r) begin
            scan_hit                 = 1'b1;
            ent_ctrl_nxt[scan_idx_r] = '0;
            res_hit_nxt              = 1'b1;
            res_idx_nxt              = 4'(scan_idx_r);
          end
        end
        OP_RECORD: begin
          if (ent_ctrl_r[scan_idx_r] == 7'd0) begin
            scan_hit                 = 1'b1;
            ent_seq_nxt[scan_idx_r]  = rseq_r;
            ent_ctrl_nxt[scan_idx_r] = rctrl_r;
            ent_time_nxt[scan_idx_r] = time_r;
            res_kind_nxt             = KIND_RECORDED;
            res_idx_nxt              = 4'(scan_idx_r);
          end
        end
        OP_TICK: begin
          if (ent_ctrl_r[scan_idx_r] != 7'd0 &&
              (time_r - ent_time_r[scan_idx_r]) > age_lim_r) begin
            ent_ctrl_nxt[scan_idx_r] = '0;
            ent_time_nxt[scan_idx_r] = '0;
          end
        end
        default: scan_hit = 1'b0;
      endcase
    end

    if (cmd.emit) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  assign sts.need_scan = need_scan;
  assign sts.scan_done = scan_hit || (scan_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.res_valid = res_valid_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_frame_seq      = out_seq_r;
  assign out_frame_ctrl     = out_ctrl_r;
  assign out_payload_length = out_len_r;
  assign out_matched        = out_hit_r;
  assign out_entry_index    = out_idx_r;

endmodule

/* rtl/reply_frame_parser_with_request_table_unit.sv */
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall  opcode, rx_byte, request_seq, request_ctrl
// out_      output     out_valid/out_stall kind, frame_seq, frame_ctrl, payload_length,
//                                          matched, entry_index
// cfg_      input      cfg_we             cfg_index, cfg_data (no read-back)
//
// One word at a time: accept, execute, a table scan of one entry per cycle when needed,
// then handoff of any result, which waits while the output word is still stalled. Ticks
// scan all entries; record and match scans stop at the first hit.
// Reset (rst_n low, synchronous) stalls the input, frees every table entry,
// clears parser and time, and loads the register defaults.
// A waiting output word does not block intake; only the next handoff waits for it.
module reply_frame_parser_with_request_table_unit import rfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_request_seq,
  input  logic [6:0]  in_request_ctrl,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_frame_seq,
  output logic [7:0]  out_frame_ctrl,
  output logic [15:0] out_payload_length,
  output logic        out_matched,
  output logic [3:0]  out_entry_index
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle / execute / scan / hand off
  rfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parser state, request table, result and output registers
  rfp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (in_opcode),
    .in_rx_byte         (in_rx_byte),
    .in_request_seq     (in_request_seq),
    .in_request_ctrl    (in_request_ctrl),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_frame_seq      (out_frame_seq),
    .out_frame_ctrl     (out_frame_ctrl),
    .out_payload_length (out_payload_length),
    .out_matched        (out_matched),
    .out_entry_index    (out_entry_index),
    .cmd                (cmd),
    .sts                (sts)
  );

  // a handoff never overwrites a word still waiting at the output
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result handed off over a waiting output word");

  // an accepted word is executed in the very next cycle
  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.exec)
    else $error("accepted word not executed");

  // a handoff always shows up on the output next cycle
  a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("handed-off result not presented");

  // no intake while the sequencer is busy
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.scan) |-> in_stall)
    else $error("input open while a word is in progress");

endmodule
